/* src/umsf_pkg.sv */
// Shared types and constants for the USB-MIDI packet to serial byte queue.
// No dependencies; used by the top level and its port checker.
package umsf_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int COUNT_W = 2;
   localparam int CODE_W = 4;
   localparam int BYTE_W = 8;

   typedef enum logic {
      OP_PACKET = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   // MIDI bytes carried by each code index
   localparam logic [COUNT_W-1:0] BYTE_COUNT_TABLE [16] = '{
      2'd0, 2'd0, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2, 2'd3,
      2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd1
   };

   // result waiting for the queue read data
   typedef struct packed {
      logic              send_valid;
      logic              accepted;
      logic              dropped;
      logic              use_mem;
      logic [BYTE_W-1:0] byte_fwd;
   } stage_type;

endpackage

/* src/usb_midi_packet_to_serial_fifo_unit.sv */
// USB-MIDI event packets in, MIDI bytes for the serial transmitter out.
// Ring queue in a single-port-write synchronous memory; uses umsf_pkg.
//
// Each accepted item gives one result item, through the stage register and
// then the output register. A packet that queues more than one MIDI byte
// holds off the input until its later bytes are written, as the byte queue
// memory has a single write port. The queue has QUEUE_DEPTH slots
// and holds QUEUE_DEPTH-1 bytes; a packet that does not fit is dropped whole
// and flagged. A packet arriving while the line is idle sends its first byte
// in its own result. Results wait in an output register, so new items are
// accepted while a result is still pending.
module usb_midi_packet_to_serial_fifo_unit #(
   parameter int QUEUE_DEPTH = umsf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_operation,
   input  logic [umsf_pkg::CODE_W-1:0] req_code_index,
   input  logic [umsf_pkg::BYTE_W-1:0] req_midi_first,
   input  logic [umsf_pkg::BYTE_W-1:0] req_midi_second,
   input  logic [umsf_pkg::BYTE_W-1:0] req_midi_third,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_send_valid,
   output logic [umsf_pkg::BYTE_W-1:0] rsp_send_byte,
   output logic                        rsp_accepted,
   output logic                        rsp_dropped
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int SUM_W = PTR_W + 1;
   localparam int BW = umsf_pkg::BYTE_W;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
      if (s == PTR_W'(QUEUE_DEPTH - 1)) return '0;
      return s + 1'b1;
   endfunction

   logic [BW-1:0] queue_mem [QUEUE_DEPTH];
   logic [BW-1:0] rd_data_ff;

   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic             line_idle_ff, line_idle_in;

   // background writes of the second and third packet bytes
   logic [umsf_pkg::COUNT_W-1:0] wr_left_ff, wr_left_in;
   logic [PTR_W-1:0]             wr_addr_ff, wr_addr_in;
   logic [BW-1:0]                byte1_ff, byte1_in;
   logic [BW-1:0]                byte2_ff, byte2_in;

   logic                 s1_valid_ff, s1_valid_in;
   umsf_pkg::stage_type  s1_ff, s1_in;

   logic          out_valid_ff, out_valid_in;
   logic          out_send_valid_ff, out_accepted_ff, out_dropped_ff;
   logic [BW-1:0] out_byte_ff;

   logic                         accept, s1_adv, busy;
   logic                         is_tick, empty, drop, pop;
   logic [umsf_pkg::COUNT_W-1:0] count;
   logic [SUM_W-1:0]             fill, room, wr_sum;
   logic [PTR_W-1:0]             wr_adv;
   logic                         mem_we;
   logic [PTR_W-1:0]             mem_waddr;
   logic [BW-1:0]                mem_wdata;

   assign busy   = (wr_left_ff != '0);
   assign s1_adv = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !busy && (!s1_valid_ff || s1_adv);
   assign accept = req_valid && req_ready;

   assign is_tick = (umsf_pkg::op_type'(req_operation) == umsf_pkg::OP_TICK);
   assign count   = umsf_pkg::BYTE_COUNT_TABLE[req_code_index];
   assign empty   = (rd_ptr_ff == wr_ptr_ff);

   always_comb begin
      if (wr_ptr_ff >= rd_ptr_ff) begin
         fill = {1'b0, wr_ptr_ff} - {1'b0, rd_ptr_ff};
      end else begin
         fill = {1'b0, wr_ptr_ff} + SUM_W'(QUEUE_DEPTH) - {1'b0, rd_ptr_ff};
      end
      room   = SUM_W'(QUEUE_DEPTH - 1) - fill;
      wr_sum = {1'b0, wr_ptr_ff} + SUM_W'(count);
      if (wr_sum >= SUM_W'(QUEUE_DEPTH)) begin
         wr_adv = PTR_W'(wr_sum - SUM_W'(QUEUE_DEPTH));
      end else begin
         wr_adv = wr_sum[PTR_W-1:0];
      end
   end

   assign drop = !is_tick && (SUM_W'(count) > room);
   // tick pops when non-empty; a packet pops its first byte if the line idles
   assign pop  = is_tick ? !empty : (!drop && count != '0 && line_idle_ff);

   always_comb begin
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      line_idle_in = line_idle_ff;
      wr_left_in   = busy ? wr_left_ff - 1'b1 : wr_left_ff;
      wr_addr_in   = busy ? next_slot(wr_addr_ff) : wr_addr_ff;
      byte1_in     = busy ? byte2_ff : byte1_ff;
      byte2_in     = byte2_ff;
      mem_we       = busy;
      mem_waddr    = wr_addr_ff;
      mem_wdata    = byte1_ff;
      s1_in        = s1_ff;
      if (accept) begin
         s1_in.send_valid = pop;
         s1_in.accepted   = !is_tick && !drop;
         s1_in.dropped    = drop;
         // packet into an empty queue: the popped byte is still being written
         s1_in.use_mem    = pop && !empty;
         s1_in.byte_fwd   = (pop && empty) ? req_midi_first : '0;
         if (pop) begin
            rd_ptr_in    = next_slot(rd_ptr_ff);
            line_idle_in = 1'b0;
         end else if (is_tick) begin
            line_idle_in = 1'b1;
         end
         if (!is_tick && !drop && count != '0) begin
            wr_ptr_in  = wr_adv;
            mem_we     = 1'b1;
            mem_waddr  = wr_ptr_ff;
            mem_wdata  = req_midi_first;
            wr_left_in = count - 1'b1;
            wr_addr_in = next_slot(wr_ptr_ff);
            byte1_in   = req_midi_second;
            byte2_in   = req_midi_third;
         end
      end
   end

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rd_data_ff <= queue_mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         line_idle_ff <= 1'b1;
         wr_left_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         line_idle_ff <= line_idle_in;
         wr_left_ff   <= wr_left_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      byte1_ff   <= byte1_in;
      byte2_ff   <= byte2_in;
      s1_ff      <= s1_in;
      if (s1_adv) begin
         out_send_valid_ff <= s1_ff.send_valid;
         out_accepted_ff   <= s1_ff.accepted;
         out_dropped_ff    <= s1_ff.dropped;
         out_byte_ff       <= s1_ff.use_mem ? rd_data_ff : s1_ff.byte_fwd;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_send_valid = out_send_valid_ff;
   assign rsp_send_byte  = out_byte_ff;
   assign rsp_accepted   = out_accepted_ff;
   assign rsp_dropped    = out_dropped_ff;

endmodule

/* src/umsf_checker.sv */
// Port-level checks for usb_midi_packet_to_serial_fifo_unit, bound to it below.
// Uses umsf_pkg for field widths.
module umsf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_send_valid,
   input logic [umsf_pkg::BYTE_W-1:0] rsp_send_byte,
   input logic                        rsp_accepted,
   input logic                        rsp_dropped
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_dropped))
      else $error("item both accepted and dropped");

   a_drop_no_send: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |-> !rsp_send_valid)
      else $error("dropped packet sent a byte");

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_send_valid) |-> (rsp_send_byte == '0))
      else $error("byte nonzero with no send");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_send_byte)
         && $stable(rsp_send_valid) && $stable(rsp_accepted) && $stable(rsp_dropped)))
      else $error("result changed while stalled");

endmodule

bind usb_midi_packet_to_serial_fifo_unit umsf_checker u_umsf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_send_valid (rsp_send_valid),
   .rsp_send_byte  (rsp_send_byte),
   .rsp_accepted   (rsp_accepted),
   .rsp_dropped    (rsp_dropped)
);

/* bench/tb_usb_midi_packet_to_serial_fifo_unit.sv */
// Self-checking bench for usb_midi_packet_to_serial_fifo_unit: packets and
// transmitter ticks in, one checked result item per input item out.
// Depends on umsf_pkg and the top level of the block only.
module tb_usb_midi_packet_to_serial_fifo_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = umsf_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 500;

   typedef struct {
      umsf_pkg::op_type op;
      bit [3:0]         code_index;
      bit [7:0]         first;
      bit [7:0]         second;
      bit [7:0]         third;
      bit               drain_first;   // hold until every result is back
   } midi_event_type;

   typedef struct packed {
      bit       send_valid;
      bit [7:0] send_byte;
      bit       accepted;
      bit       dropped;
   } serial_result_type;

   // MIDI bytes per code index
   localparam int BYTES_PER_CODE [16] = '{0, 0, 2, 3, 3, 1, 2, 3, 3, 3, 3, 3, 2, 2, 3, 1};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_operation = 1'b0;
   logic [3:0] req_code_index = '0;
   logic [7:0] req_midi_first = '0;
   logic [7:0] req_midi_second = '0;
   logic [7:0] req_midi_third = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_send_valid;
   logic [7:0] rsp_send_byte;
   logic       rsp_accepted;
   logic       rsp_dropped;

   usb_midi_packet_to_serial_fifo_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_code_index  (req_code_index),
      .req_midi_first  (req_midi_first),
      .req_midi_second (req_midi_second),
      .req_midi_third  (req_midi_third),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_send_valid  (rsp_send_valid),
      .rsp_send_byte   (rsp_send_byte),
      .rsp_accepted    (rsp_accepted),
      .rsp_dropped     (rsp_dropped)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   midi_event_type    event_backlog [$];
   midi_event_type    in_flight;
   serial_result_type expected_serial [$];
   int                total_events;
   int                predicted_count = 0;
   int                checked_count = 0;
   int                failures = 0;
   int                cycles = 0;

   // predictor state
   bit [7:0] byte_store [DEPTH];
   int       rd_slot;
   int       wr_slot;
   bit       line_idle;

   function automatic serial_result_type forward_event(input midi_event_type ev);
      serial_result_type r;
      bit [7:0]          b [3];
      int                n;
      int                fill;
      r = '0;
      if (ev.op == umsf_pkg::OP_TICK) begin
         if (rd_slot != wr_slot) begin
            r.send_valid = 1'b1;
            r.send_byte = byte_store[rd_slot];
            rd_slot = (rd_slot + 1) % DEPTH;
            line_idle = 1'b0;
         end else begin
            line_idle = 1'b1;
         end
      end else begin
         n = BYTES_PER_CODE[ev.code_index];
         fill = (wr_slot + DEPTH - rd_slot) % DEPTH;
         if (n > DEPTH - 1 - fill) begin
            r.dropped = 1'b1;
         end else begin
            b[0] = ev.first;
            b[1] = ev.second;
            b[2] = ev.third;
            for (int i = 0; i < n; i++) begin
               byte_store[wr_slot] = b[i];
               wr_slot = (wr_slot + 1) % DEPTH;
            end
            r.accepted = 1'b1;
            // idle line: first byte goes straight out
            if (n > 0 && line_idle) begin
               r.send_valid = 1'b1;
               r.send_byte = byte_store[rd_slot];
               rd_slot = (rd_slot + 1) % DEPTH;
               line_idle = 1'b0;
            end
         end
      end
      return r;
   endfunction

   function automatic bit [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic add_event(input umsf_pkg::op_type op, input bit [3:0] code,
                            input bit [7:0] first, input bit [7:0] second,
                            input bit [7:0] third, input bit drain_first);
      midi_event_type ev;
      ev.op = op;
      ev.code_index = code;
      ev.first = first;
      ev.second = second;
      ev.third = third;
      ev.drain_first = drain_first;
      event_backlog.push_back(ev);
   endtask

   // sender: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left = 0;
   int owed;
   bit fire;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         predicted_count <= 0;
         rd_slot = 0;
         wr_slot = 0;
         line_idle = 1'b1;
         burst_left = $urandom_range(1, 30);
         gap_left = 0;
      end else begin
         fire = req_valid && req_ready;
         if (fire) begin
            expected_serial.push_back(forward_event(in_flight));
            predicted_count <= predicted_count + 1;
         end
         if (!req_valid || fire) begin
            owed = predicted_count + (fire ? 1 : 0) - checked_count;
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (event_backlog.size() > 0 &&
                         !(event_backlog[0].drain_first && owed != 0)) begin
               in_flight = event_backlog.pop_front();
               req_valid <= 1'b1;
               req_operation <= in_flight.op;
               req_code_index <= in_flight.code_index;
               req_midi_first <= in_flight.first;
               req_midi_second <= in_flight.second;
               req_midi_third <= in_flight.third;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = $urandom_range(0, 7);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         failures++;
      end
   endfunction

   // receiver: stall pattern redrawn at random from time to time
   int                stall_mode = 0;
   int                mode_cycles = 0;
   serial_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         checked_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (checked_count >= predicted_count) begin
               $display("%0t: unexpected result item, actual send_valid %0h send_byte %0h"
                        , $time, rsp_send_valid, rsp_send_byte);
               failures++;
            end else begin
               want = expected_serial[checked_count];
               check_field("send_valid", want.send_valid, rsp_send_valid);
               check_field("send_byte", want.send_byte, rsp_send_byte);
               check_field("accepted", want.accepted, rsp_accepted);
               check_field("dropped", want.dropped, rsp_dropped);
               checked_count <= checked_count + 1;
            end
         end
         mode_cycles++;
         if (mode_cycles >= 100) begin
            mode_cycles = 0;
            stall_mode = $urandom_range(0, 3);
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 9) < 7);
            2: rsp_ready <= (mode_cycles % 4 == 0);
            default: rsp_ready <= ($urandom_range(0, 9) < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_usb_midi_packet_to_serial_fifo_unit NOT OK");
         $finish;
      end
   end

   initial begin
      bit [3:0] fill_codes [8];
      bit [3:0] late_codes [5];
      int       seg_len;
      int       tick_pct;
      int       made;
      fill_codes = '{4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd12, 4'd15};
      late_codes = '{4'd9, 4'd10, 4'd11, 4'd13, 4'd14};

      // tick on empty queue, fields ignored; empty packets; a single-byte packet
      add_event(umsf_pkg::OP_TICK, 4'hF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      add_event(umsf_pkg::OP_PACKET, 4'h0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      add_event(umsf_pkg::OP_PACKET, 4'h1, 8'h00, 8'h00, 8'h00, 1'b0);
      add_event(umsf_pkg::OP_PACKET, 4'h5, 8'hFF, 8'h00, 8'hFF, 1'b0);
      // line busy: fill until packets no longer fit
      foreach (fill_codes[k])
         add_event(umsf_pkg::OP_PACKET, fill_codes[k], 8'h80 | 8'(k), 8'hFF, 8'h00, 1'b0);
      add_event(umsf_pkg::OP_TICK, 4'h0, 8'h00, 8'h00, 8'h00, 1'b1);
      repeat (4) add_event(umsf_pkg::OP_TICK, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0);
      foreach (late_codes[k])
         add_event(umsf_pkg::OP_PACKET, late_codes[k], 8'h00, 8'hFF, 8'h55, 1'b0);

      // random segments, each leaning toward filling or draining the queue
      made = 0;
      while (made < RANDOM_ITEMS) begin
         seg_len = $urandom_range(8, 40);
         case ($urandom_range(0, 2))
            0: tick_pct = 15;
            1: tick_pct = 50;
            default: tick_pct = 85;
         endcase
         for (int i = 0; i < seg_len && made < RANDOM_ITEMS; i++) begin
            add_event(($urandom_range(0, 99) < tick_pct) ? umsf_pkg::OP_TICK
                                                         : umsf_pkg::OP_PACKET,
                      4'($urandom), pick_byte(), pick_byte(), pick_byte(),
                      $urandom_range(0, 99) == 0);
            made++;
         end
      end
      total_events = event_backlog.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (predicted_count != total_events) @(posedge clock);
      while (checked_count != predicted_count) @(posedge clock);
      repeat (16) @(posedge clock);
      if (failures == 0)
         $display("tb_usb_midi_packet_to_serial_fifo_unit OK");
      else
         $display("tb_usb_midi_packet_to_serial_fifo_unit NOT OK");
      $finish;
   end

endmodule
